// File: design/mppf_pkg.sv
package mppf_pkg;

  // request kinds on the input channel
  localparam logic [1:0] KIND_PAT_BYTE = 2'd0;
  localparam logic [1:0] KIND_PAT_LEN  = 2'd1;
  localparam logic [1:0] KIND_TEXT     = 2'd2;
  localparam logic [1:0] KIND_CLEAR    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_PREFIX_LENGTH = 2'd0;
  localparam logic [1:0] CFG_PATTERN_COUNT = 2'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] pattern_index;
    logic [3:0] byte_position;
    logic [7:0] value;
    logic       last;
  } mppf_in_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  matched_pattern;
    logic [31:0] match_start;
    logic [31:0] match_end;
  } mppf_out_t;

  // pattern store write controls
  typedef struct packed {
    logic       byte_we;
    logic       len_we;
    logic       clear;
    logic [5:0] pidx;
    logic [3:0] bpos;
    logic [7:0] value;
  } mppf_wr_t;

  // nibble mask build controls (pos covers up to four prefix positions)
  typedef struct packed {
    logic       clear;
    logic       set;
    logic [1:0] pos;
    logic [7:0] data;
  } mppf_mask_ctl_t;

endpackage

// File: design/multi_pattern_prefix_filter_matcher_top.sv
// channel | signals                          | moves
// in      | in_valid, in_ready, in_data      | one request: pattern write, clear or text byte
// out     | out_valid, out_ready, out_data   | one result after a text byte marked last
// cfg     | cfg_valid, cfg_ready, cfg_index, | register write, always ready
//         | cfg_data                         |
//
// pattern writes and clears are taken in the idle state. a text byte is checked against each
// active pattern in turn (length and candidate check, then a byte compare), then the end state runs;
// the byte compare is shared over the pattern store read port.
// after any pattern or register change the next text byte first rebuilds the nibble masks
// from every active pattern that is long enough for the prefix.
// reset is synchronous; no clearing pass. a result waiting on out holds the end of the next
// text until it is taken; in_ready is low while a request is being worked on.
module multi_pattern_prefix_filter_matcher_top import mppf_pkg::*; #(
  parameter int MAX_PATTERNS    = 64,
  parameter int NUM_BUCKETS     = 8,
  parameter int MAX_PATTERN_LEN = 16,
  parameter int MAX_PREFIX      = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  mppf_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output mppf_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int PW = $clog2(MAX_PATTERNS);
  localparam int AW = $clog2(MAX_PATTERNS * MAX_PATTERN_LEN);
  localparam int LW = $clog2(MAX_PATTERN_LEN + 1);
  localparam int JW = $clog2(MAX_PATTERN_LEN);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_R_START = 4'd1;
  localparam logic [3:0] S_R_LEN   = 4'd2;
  localparam logic [3:0] S_R_CHK   = 4'd3;
  localparam logic [3:0] S_R_BYTE  = 4'd4;
  localparam logic [3:0] S_T_ENTRY = 4'd5;
  localparam logic [3:0] S_V_LEN   = 4'd6;
  localparam logic [3:0] S_V_CHK   = 4'd7;
  localparam logic [3:0] S_V_CMP   = 4'd8;
  localparam logic [3:0] S_V_END   = 4'd9;

  logic [3:0] state;

  // registers
  logic [2:0] prefix_length;
  logic [6:0] pattern_count;
  logic       dirty;

  // latched text byte
  logic [7:0] tbyte;
  logic       tlast;

  // search state
  logic [NUM_BUCKETS-1:0] hist      [MAX_PREFIX];
  logic [NUM_BUCKETS-1:0] cand_ring [MAX_PATTERN_LEN];
  logic [7:0]             window    [MAX_PATTERN_LEN];
  logic [JW-1:0]          wr_pos;
  logic [LW-1:0]          fill;
  logic [31:0]            offset;
  logic                   best_valid;
  logic [PW-1:0]          best_id;
  logic [31:0]            best_start;
  logic [31:0]            best_end;

  // loop counters
  logic [6:0]    pc;
  logic [JW-1:0] vj;
  logic [JW-1:0] vidx;
  logic [LW-1:0] vlen;

  logic [2:0] np_eff;
  logic [6:0] cnt_eff;
  logic       last_pat;

  mppf_wr_t       wr;
  mppf_mask_ctl_t mctl;
  logic [NUM_BUCKETS-1:0] bsel;
  logic [NUM_BUCKETS-1:0] hit [MAX_PREFIX];
  logic [LW-1:0] len_q;
  logic [7:0]    byte_q;
  logic [AW-1:0] byte_addr;
  logic          in_acc;

  // effective prefix and pattern count
  always_comb begin
    np_eff = prefix_length;
    if (np_eff < 3'd1) np_eff = 3'd1;
    if (np_eff > 3'(MAX_PREFIX)) np_eff = 3'(MAX_PREFIX);
    cnt_eff = pattern_count;
    if (cnt_eff > 7'(MAX_PATTERNS)) cnt_eff = 7'(MAX_PATTERNS);
    if (cnt_eff > 7'(NUM_BUCKETS * 8)) cnt_eff = 7'(NUM_BUCKETS * 8);
  end

  assign last_pat = (pc + 7'd1) >= cnt_eff;
  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc = in_valid && in_ready;

  // bucket of the pattern under the counter
  always_comb begin
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      bsel[b] = ((pc >> 3) == 7'(b));
    end
  end

  // pattern store writes straight from the accepted request
  always_comb begin
    wr.byte_we = in_acc && (in_data.kind == KIND_PAT_BYTE)
                 && (7'(in_data.pattern_index) < 7'(MAX_PATTERNS))
                 && (7'(in_data.byte_position) < 7'(MAX_PATTERN_LEN));
    wr.len_we  = in_acc && (in_data.kind == KIND_PAT_LEN)
                 && (7'(in_data.pattern_index) < 7'(MAX_PATTERNS));
    wr.clear   = in_acc && (in_data.kind == KIND_CLEAR);
    wr.pidx    = in_data.pattern_index;
    wr.bpos    = in_data.byte_position;
    wr.value   = in_data.value;
  end

  // shared byte read address: first byte on check states, next byte while comparing or building masks
  always_comb begin
    logic [JW-1:0] jsel;
    jsel = '0;
    if (state == S_V_CMP || state == S_R_BYTE) jsel = vj + JW'(1);
    byte_addr = AW'(pc[PW-1:0]) * AW'(MAX_PATTERN_LEN) + AW'(jsel);
  end

  mppf_pat_mem #(
    .MAX_PATTERNS   (MAX_PATTERNS),
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .len_addr (pc[PW-1:0]),
    .byte_addr(byte_addr),
    .len_q    (len_q),
    .byte_q   (byte_q)
  );

  always_comb begin
    mctl.clear = (state == S_R_START);
    mctl.set   = (state == S_R_BYTE);
    mctl.pos   = 2'(vj);
    mctl.data  = byte_q;
  end

  mppf_nibble_filter #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .MAX_PREFIX (MAX_PREFIX)
  ) u_filter (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mctl),
    .bucket(bsel),
    .look  (tbyte),
    .hit   (hit)
  );

  // text entry: ring pointer, fill and candidate history
  logic [JW-1:0]          wr_next;
  logic [LW-1:0]          fill_next;
  logic [NUM_BUCKETS-1:0] hist_next [MAX_PREFIX];
  logic [NUM_BUCKETS-1:0] cand_new;
  logic [JW:0]            cwp_sum;
  logic [JW-1:0]          cand_wp;

  always_comb begin
    wr_next = (wr_pos == JW'(MAX_PATTERN_LEN - 1)) ? '0 : wr_pos + JW'(1);
    fill_next = (fill < LW'(MAX_PATTERN_LEN)) ? fill + LW'(1) : fill;
    cand_new = '0;
    for (int k = 0; k < MAX_PREFIX; k++) begin
      if (k == 0) begin
        hist_next[k] = hit[k];
      end else if (3'(k) < np_eff) begin
        hist_next[k] = hist[k-1] & hit[k];
      end else begin
        hist_next[k] = hist[k];
      end
    end
    for (int k = 0; k < MAX_PREFIX; k++) begin
      if (3'(k) + 3'd1 == np_eff) cand_new = hist_next[k];
    end
    cwp_sum = (JW+1)'(wr_next) + (JW+1)'(MAX_PATTERN_LEN) - (JW+1)'(np_eff - 3'd1);
    cand_wp = (cwp_sum >= (JW+1)'(MAX_PATTERN_LEN)) ?
              JW'(cwp_sum - (JW+1)'(MAX_PATTERN_LEN)) : JW'(cwp_sum);
  end

  // verify: start slot of the candidate, byte compare and leftmost update
  logic [JW:0]   idx_sum;
  logic [JW-1:0] idx_mod;
  logic          cand_bit;
  logic [JW:0]   wsum;
  logic [JW-1:0] wpos;
  logic [31:0]   mstart;
  logic          better;

  always_comb begin
    idx_sum = (JW+1)'(wr_pos) + (JW+1)'(MAX_PATTERN_LEN) - (JW+1)'(len_q - LW'(1));
    idx_mod = (idx_sum >= (JW+1)'(MAX_PATTERN_LEN)) ?
              JW'(idx_sum - (JW+1)'(MAX_PATTERN_LEN)) : JW'(idx_sum);
    cand_bit = |(cand_ring[idx_mod] & bsel);
    wsum = (JW+1)'(vidx) + (JW+1)'(vj);
    wpos = (wsum >= (JW+1)'(MAX_PATTERN_LEN)) ?
           JW'(wsum - (JW+1)'(MAX_PATTERN_LEN)) : JW'(wsum);
    mstart = offset + 32'd1 - 32'(vlen);
    better = !best_valid || (mstart < best_start)
             || ((mstart == best_start) && (pc < 7'(best_id)));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prefix_length <= 3'd1;
      pattern_count <= 7'd0;
      dirty         <= 1'b0;
      out_valid     <= 1'b0;
      for (int k = 0; k < MAX_PREFIX; k++) hist[k] <= '1;
      for (int k = 0; k < MAX_PATTERN_LEN; k++) cand_ring[k] <= '0;
      wr_pos        <= JW'(MAX_PATTERN_LEN - 1);
      fill          <= '0;
      offset        <= '0;
      best_valid    <= 1'b0;
      best_id       <= '0;
      best_start    <= '0;
      best_end      <= '0;
      pc            <= '0;
      vj            <= '0;
    end else begin
      // the end state publishes on its own when a final text byte finishes
      if (out_valid && out_ready && !(state == S_V_END && tlast)) out_valid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PREFIX_LENGTH: begin
            prefix_length <= cfg_data[2:0];
            dirty <= 1'b1;
          end
          CFG_PATTERN_COUNT: begin
            pattern_count <= cfg_data[6:0];
            dirty <= 1'b1;
          end
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_data.kind)
              KIND_PAT_BYTE: if (wr.byte_we) dirty <= 1'b1;
              KIND_PAT_LEN:  if (wr.len_we) dirty <= 1'b1;
              KIND_CLEAR:    dirty <= 1'b1;
              KIND_TEXT: begin
                tbyte <= in_data.value;
                tlast <= in_data.last;
                state <= dirty ? S_R_START : S_T_ENTRY;
              end
              default: ;
            endcase
          end
        end
        S_R_START: begin
          pc <= '0;
          if (cnt_eff == 7'd0) begin
            dirty <= 1'b0;
            state <= S_T_ENTRY;
          end else begin
            state <= S_R_LEN;
          end
        end
        S_R_LEN: state <= S_R_CHK;
        S_R_CHK: begin
          vj <= '0;
          if (8'(len_q) >= 8'(np_eff)) begin
            state <= S_R_BYTE;
          end else if (last_pat) begin
            dirty <= 1'b0;
            state <= S_T_ENTRY;
          end else begin
            pc <= pc + 7'd1;
            state <= S_R_LEN;
          end
        end
        S_R_BYTE: begin
          if (8'(vj) + 8'd1 == 8'(np_eff)) begin
            if (last_pat) begin
              dirty <= 1'b0;
              state <= S_T_ENTRY;
            end else begin
              pc <= pc + 7'd1;
              state <= S_R_LEN;
            end
          end else begin
            vj <= vj + JW'(1);
          end
        end
        S_T_ENTRY: begin
          wr_pos <= wr_next;
          window[wr_next] <= tbyte;
          fill <= fill_next;
          for (int k = 0; k < MAX_PREFIX; k++) hist[k] <= hist_next[k];
          if (8'(fill_next) >= 8'(np_eff)) cand_ring[cand_wp] <= cand_new;
          pc <= '0;
          state <= (cnt_eff == 7'd0) ? S_V_END : S_V_LEN;
        end
        S_V_LEN: state <= S_V_CHK;
        S_V_CHK: begin
          vj <= '0;
          vidx <= idx_mod;
          vlen <= len_q;
          if ((8'(len_q) < 8'(np_eff)) || (8'(len_q) > 8'(fill)) || !cand_bit) begin
            if (last_pat) begin
              state <= S_V_END;
            end else begin
              pc <= pc + 7'd1;
              state <= S_V_LEN;
            end
          end else begin
            state <= S_V_CMP;
          end
        end
        S_V_CMP: begin
          if ((window[wpos] != byte_q) || (8'(vj) + 8'd1 == 8'(vlen))) begin
            if ((window[wpos] == byte_q) && better) begin
              best_valid <= 1'b1;
              best_id    <= pc[PW-1:0];
              best_start <= mstart;
              best_end   <= offset + 32'd1;
            end
            if (last_pat) begin
              state <= S_V_END;
            end else begin
              pc <= pc + 7'd1;
              state <= S_V_LEN;
            end
          end else begin
            vj <= vj + JW'(1);
          end
        end
        S_V_END: begin
          if (!tlast) begin
            offset <= offset + 32'd1;
            state <= S_IDLE;
          end else if (!out_valid || out_ready) begin
            // publish the result and start a fresh text
            out_valid <= 1'b1;
            out_data.found           <= best_valid;
            out_data.matched_pattern <= best_valid ? 6'(best_id) : 6'd0;
            out_data.match_start     <= best_valid ? best_start : 32'd0;
            out_data.match_end       <= best_valid ? best_end : 32'd0;
            for (int k = 0; k < MAX_PREFIX; k++) hist[k] <= '1;
            for (int k = 0; k < MAX_PATTERN_LEN; k++) cand_ring[k] <= '0;
            wr_pos     <= JW'(MAX_PATTERN_LEN - 1);
            fill       <= '0;
            offset     <= '0;
            best_valid <= 1'b0;
            best_id    <= '0;
            best_start <= '0;
            best_end   <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // byte compare never runs past the pattern length
  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_V_CMP) |-> (8'(vj) < 8'(vlen)))
    else $error("compare index beyond pattern length");

  // window fill saturates at the window depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    8'(fill) <= 8'(MAX_PATTERN_LEN))
    else $error("window fill overflow");

  // filtering only runs on up-to-date masks
  a_masks_fresh: assert property (@(posedge clk) disable iff (rst)
    (state == S_T_ENTRY) |-> !dirty)
    else $error("text byte filtered with stale masks");

  // pattern loop stays inside the active set
  a_pc_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_V_LEN) |-> (pc < cnt_eff))
    else $error("pattern counter beyond active count");

endmodule

// File: design/mppf_pat_mem.sv
module mppf_pat_mem import mppf_pkg::*; #(
  parameter int MAX_PATTERNS    = 64,
  parameter int MAX_PATTERN_LEN = 16,
  localparam int PW = $clog2(MAX_PATTERNS),
  localparam int AW = $clog2(MAX_PATTERNS * MAX_PATTERN_LEN),
  localparam int LW = $clog2(MAX_PATTERN_LEN + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  mppf_wr_t      wr,
  input  logic [PW-1:0] len_addr,
  input  logic [AW-1:0] byte_addr,
  output logic [LW-1:0] len_q,
  output logic [7:0]    byte_q
);

  logic [7:0]              byte_mem [MAX_PATTERNS * MAX_PATTERN_LEN];
  logic [LW-1:0]           len_mem  [MAX_PATTERNS];
  logic [MAX_PATTERNS-1:0] len_valid;

  logic [AW-1:0] waddr;
  logic [LW-1:0] len_sat;

  assign waddr = AW'(wr.pidx[PW-1:0]) * AW'(MAX_PATTERN_LEN) + AW'(wr.bpos);
  assign len_sat = (wr.value > 8'(MAX_PATTERN_LEN)) ? LW'(MAX_PATTERN_LEN) : LW'(wr.value);

  always_ff @(posedge clk) begin
    if (wr.byte_we) begin
      byte_mem[waddr] <= wr.value;
    end
    byte_q <= byte_mem[byte_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.len_we) begin
      len_mem[wr.pidx[PW-1:0]] <= len_sat;
    end
    len_q <= len_valid[len_addr] ? len_mem[len_addr] : '0;
  end

  // unwritten or cleared lengths read as zero
  always_ff @(posedge clk) begin
    if (rst || wr.clear) begin
      len_valid <= '0;
    end else if (wr.len_we) begin
      len_valid[wr.pidx[PW-1:0]] <= 1'b1;
    end
  end

endmodule

// File: design/mppf_nibble_filter.sv
module mppf_nibble_filter import mppf_pkg::*; #(
  parameter int NUM_BUCKETS = 8,
  parameter int MAX_PREFIX  = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mppf_mask_ctl_t         ctl,
  input  logic [NUM_BUCKETS-1:0] bucket,
  input  logic [7:0]             look,
  output logic [NUM_BUCKETS-1:0] hit [MAX_PREFIX]
);

  logic [NUM_BUCKETS-1:0] lo_mask [MAX_PREFIX][16];
  logic [NUM_BUCKETS-1:0] hi_mask [MAX_PREFIX][16];

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < MAX_PREFIX; i++) begin
        for (int n = 0; n < 16; n++) begin
          lo_mask[i][n] <= '0;
          hi_mask[i][n] <= '0;
        end
      end
    end else if (ctl.set) begin
      for (int i = 0; i < MAX_PREFIX; i++) begin
        if (ctl.pos == 2'(i)) begin
          lo_mask[i][ctl.data[3:0]] <= lo_mask[i][ctl.data[3:0]] | bucket;
          hi_mask[i][ctl.data[7:4]] <= hi_mask[i][ctl.data[7:4]] | bucket;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PREFIX; i++) begin
      hit[i] = lo_mask[i][look[3:0]] & hi_mask[i][look[7:4]];
    end
  end

endmodule

// File: dv/mppf_scoreboard.sv
module mppf_scoreboard import mppf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  mppf_in_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  mppf_out_t  out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         pending,
  output int         failures,
  output int         results_seen
);

  localparam int NPAT = 64;
  localparam int PLEN = 16;
  localparam int NPRE = 4;

  logic [7:0]  pat_mem [NPAT][PLEN];
  logic [4:0]  pat_len [NPAT];
  logic [7:0]  lo_mask [NPRE][16];
  logic [7:0]  hi_mask [NPRE][16];
  logic [7:0]  cand_hist [NPRE];
  logic [7:0]  window [PLEN];
  logic [7:0]  start_cands [PLEN];
  logic [31:0] text_pos;
  int          wr_ptr;
  int          filled;
  bit          hit_valid;
  int          hit_id;
  logic [31:0] hit_start;
  logic [31:0] hit_end;
  logic [2:0]  prefix_reg;
  logic [6:0]  count_reg;
  mppf_out_t   match_q[$];

  function automatic int active_prefix();
    if (prefix_reg < 1) return 1;
    if (prefix_reg > NPRE) return NPRE;
    return prefix_reg;
  endfunction

  function automatic int active_count();
    return (count_reg > NPAT) ? NPAT : count_reg;
  endfunction

  function automatic void build_masks();
    int np;
    logic [7:0] b;
    np = active_prefix();
    for (int i = 0; i < NPRE; i++)
      for (int n = 0; n < 16; n++) begin
        lo_mask[i][n] = '0;
        hi_mask[i][n] = '0;
      end
    for (int p = 0; p < active_count(); p++) begin
      if (pat_len[p] < np) continue;
      for (int i = 0; i < np; i++) begin
        b = pat_mem[p][i];
        lo_mask[i][b[3:0]] |= 8'(1 << (p / 8));
        hi_mask[i][b[7:4]] |= 8'(1 << (p / 8));
      end
    end
  endfunction

  function automatic void restart_text();
    for (int i = 0; i < NPRE; i++) cand_hist[i] = 8'hff;
    for (int i = 0; i < PLEN; i++) begin
      window[i] = '0;
      start_cands[i] = '0;
    end
    text_pos = '0;
    wr_ptr = PLEN - 1;
    filled = 0;
    hit_valid = 0;
    hit_id = 0;
    hit_start = '0;
    hit_end = '0;
  endfunction

  // filter, delayed exact compare, leftmost-then-lowest-id tracking
  function automatic void scan_byte(logic [7:0] b);
    int np, len, idx;
    bit ok;
    logic [31:0] s;
    np = active_prefix();
    wr_ptr = (wr_ptr + 1) % PLEN;
    window[wr_ptr] = b;
    if (filled < PLEN) filled++;
    for (int k = np - 1; k >= 1; k--)
      cand_hist[k] = cand_hist[k-1] & lo_mask[k][b[3:0]] & hi_mask[k][b[7:4]];
    cand_hist[0] = lo_mask[0][b[3:0]] & hi_mask[0][b[7:4]];
    if (filled >= np) start_cands[(wr_ptr + PLEN - (np - 1)) % PLEN] = cand_hist[np-1];
    for (int p = 0; p < active_count(); p++) begin
      len = pat_len[p];
      if (len < np || len > filled) continue;
      idx = (wr_ptr + PLEN - (len - 1)) % PLEN;
      if (!start_cands[idx][p / 8]) continue;
      ok = 1;
      for (int j = 0; j < len; j++)
        if (window[(idx + j) % PLEN] != pat_mem[p][j]) ok = 0;
      if (ok) begin
        s = text_pos + 32'd1 - 32'(len);
        if (!hit_valid || s < hit_start || (s == hit_start && p < hit_id)) begin
          hit_valid = 1;
          hit_id = p;
          hit_start = s;
          hit_end = text_pos + 32'd1;
        end
      end
    end
    text_pos++;
  endfunction

  function automatic void clear_patterns();
    for (int p = 0; p < NPAT; p++) begin
      pat_len[p] = '0;
      for (int j = 0; j < PLEN; j++) pat_mem[p][j] = '0;
    end
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    mppf_out_t want;
    if (rst) begin
      failures = 0;
      results_seen = 0;
      clear_patterns();
      prefix_reg = 3'd1;
      count_reg = '0;
      build_masks();
      restart_text();
      match_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (match_q.size() == 0) begin
          $display("unexpected result");
          failures++;
        end else begin
          want = match_q.pop_front();
          if (out_data.found != want.found)
            report_mismatch("found", out_data.found, want.found);
          if (out_data.matched_pattern != want.matched_pattern)
            report_mismatch("matched_pattern", out_data.matched_pattern, want.matched_pattern);
          if (out_data.match_start != want.match_start)
            report_mismatch("match_start", out_data.match_start, want.match_start);
          if (out_data.match_end != want.match_end)
            report_mismatch("match_end", out_data.match_end, want.match_end);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PREFIX_LENGTH) begin
          prefix_reg = cfg_data[2:0];
          build_masks();
        end else if (cfg_index == CFG_PATTERN_COUNT) begin
          count_reg = cfg_data[6:0];
          build_masks();
        end
      end
      if (in_valid && in_ready) begin
        case (in_data.kind)
          KIND_PAT_BYTE: begin
            pat_mem[in_data.pattern_index][in_data.byte_position] = in_data.value;
            build_masks();
          end
          KIND_PAT_LEN: begin
            pat_len[in_data.pattern_index] = (in_data.value > PLEN) ? 5'(PLEN) : in_data.value[4:0];
            build_masks();
          end
          KIND_CLEAR: begin
            clear_patterns();
            build_masks();
          end
          default: begin
            scan_byte(in_data.value);
            if (in_data.last) begin
              want.found = hit_valid;
              want.matched_pattern = hit_valid ? 6'(hit_id) : '0;
              want.match_start = hit_valid ? hit_start : '0;
              want.match_end = hit_valid ? hit_end : '0;
              match_q.push_back(want);
              restart_text();
            end
          end
        endcase
      end
    end
    pending <= match_q.size();
  end

endmodule

// File: dv/tb_multi_pattern_prefix_filter_matcher_top.sv
module tb_multi_pattern_prefix_filter_matcher_top;
  import mppf_pkg::*;

  // idle gap after the last expected result: one text byte over a full
  // pattern table plus a mask rebuild, with headroom
  localparam int SETTLE_CYCLES = 3000;
  localparam int STALL_LIMIT   = 60000;

  // register index with no register behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic       clk = 0;
  logic       rst = 1;
  logic       in_valid = 0;
  logic       in_ready;
  mppf_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 0;
  mppf_out_t  out_data;
  logic       cfg_valid = 0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  int pending, failures, results_seen;
  int requests_sent = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  bit gaps_on = 1;

  // shadow of what the testbench loaded, so texts can embed real patterns
  // and lengths are only set over bytes that have been written
  logic [7:0] loaded_bytes [64][16];
  int         loaded_len [64];
  bit         byte_written [64][16];

  multi_pattern_prefix_filter_matcher_top dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  mppf_scoreboard scoreboard (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .pending, .failures, .results_seen
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // receiver side: random stalls, none while gaps are switched off
  always @(negedge clk) begin
    out_ready = gaps_on ? ($urandom_range(99) >= 26) : 1'b1;
  end

  // watchdog: any stretch with no accepted request, result or register write
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_req(logic [1:0] kind, logic [5:0] pidx, logic [3:0] bpos,
                          logic [7:0] val, logic lst);
    while (gaps_on && $urandom_range(99) < 26) @(negedge clk);
    in_valid = 1;
    in_data.kind = kind;
    in_data.pattern_index = pidx;
    in_data.byte_position = bpos;
    in_data.value = val;
    in_data.last = lst;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
    requests_sent++;
    if (kind == KIND_CLEAR)
      for (int p = 0; p < 64; p++) begin
        loaded_len[p] = 0;
        for (int j = 0; j < 16; j++) byte_written[p][j] = 0;
      end
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  // register writes happen only with the block idle
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
    cfg_writes++;
  endtask

  task automatic load_pattern(int p, int len, bit full_range);
    logic [7:0] b;
    for (int j = 0; j < len; j++) begin
      b = full_range ? 8'($urandom_range(255)) : 8'($urandom_range(8'h41, 8'h44));
      send_req(KIND_PAT_BYTE, 6'(p), 4'(j), b, 1'($urandom_range(1)));
      loaded_bytes[p][j] = b;
      byte_written[p][j] = 1;
    end
    // a fully written pattern may get an oversized length, which saturates
    if (len == 16 && $urandom_range(1))
      send_req(KIND_PAT_LEN, 6'(p), 4'($urandom_range(15)), 8'($urandom_range(16, 255)),
               1'($urandom_range(1)));
    else
      send_req(KIND_PAT_LEN, 6'(p), 4'($urandom_range(15)), 8'(len), 1'($urandom_range(1)));
    loaded_len[p] = len;
  endtask

  // text over a small alphabet or over all byte values, usually with a loaded pattern spliced in
  task automatic send_text(int n);
    logic [7:0] txt [64];
    int q, at;
    bit wide;
    wide = ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++)
      txt[i] = wide ? 8'($urandom_range(255)) : 8'($urandom_range(8'h41, 8'h45));
    for (int t = 0; t < 3; t++) begin
      q = $urandom_range(63);
      if ($urandom_range(3) != 0 && loaded_len[q] > 0 && loaded_len[q] <= n) begin
        at = $urandom_range(n - loaded_len[q]);
        for (int j = 0; j < loaded_len[q]; j++) txt[at + j] = loaded_bytes[q][j];
      end
    end
    for (int i = 0; i < n; i++)
      send_req(KIND_TEXT, 6'($urandom_range(63)), 4'($urandom_range(15)), txt[i],
               1'(i == n - 1));
  endtask

  task automatic random_phase(int budget, int max_slot);
    int p, len;
    while (requests_sent < budget) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          p = $urandom_range(max_slot);
          len = ($urandom_range(4) == 0) ? 16 : $urandom_range(0, 6);
          load_pattern(p, len, $urandom_range(2) == 0);
        end
        3: send_req(KIND_PAT_BYTE, 6'($urandom_range(63)), 4'($urandom_range(15)),
                    8'($urandom_range(255)), 1'($urandom_range(1)));
        4: if ($urandom_range(5) == 0)
             send_req(KIND_CLEAR, 6'($urandom_range(63)), 4'($urandom_range(15)),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
        default: send_text(($urandom_range(5) == 0) ? $urandom_range(17, 40)
                                                    : $urandom_range(1, 12));
      endcase
    end
  endtask

  initial begin
    for (int p = 0; p < 64; p++) begin
      loaded_len[p] = 0;
      for (int j = 0; j < 16; j++) byte_written[p][j] = 0;
    end
    repeat (9) @(negedge clk);
    rst = 0;

    // directed: defaults, extreme bytes, zero and short lengths, ignored last flags
    write_reg(CFG_PATTERN_COUNT, 8'd64);
    send_req(KIND_TEXT, 6'd0, 4'd0, 8'h00, 1'b1);
    send_req(KIND_CLEAR, 6'd63, 4'd15, 8'hff, 1'b1);
    send_req(KIND_PAT_BYTE, 6'd0, 4'd0, 8'h00, 1'b1);
    send_req(KIND_PAT_BYTE, 6'd0, 4'd1, 8'hff, 1'b0);
    send_req(KIND_PAT_LEN, 6'd0, 4'd0, 8'd2, 1'b1);
    send_req(KIND_PAT_BYTE, 6'd63, 4'd0, 8'h5a, 1'b0);
    send_req(KIND_PAT_LEN, 6'd63, 4'd0, 8'd1, 1'b0);
    send_req(KIND_PAT_LEN, 6'd9, 4'd0, 8'd0, 1'b0);
    send_req(KIND_TEXT, 6'd0, 4'd0, 8'h5a, 1'b0);
    send_req(KIND_TEXT, 6'd0, 4'd0, 8'h00, 1'b0);
    send_req(KIND_TEXT, 6'd0, 4'd0, 8'hff, 1'b1);
    send_req(KIND_TEXT, 6'd0, 4'd0, 8'h00, 1'b0);
    send_req(KIND_TEXT, 6'd0, 4'd0, 8'hff, 1'b0);
    send_req(KIND_TEXT, 6'd0, 4'd0, 8'h5a, 1'b1);
    // a single byte pattern is too short once the prefix grows
    write_reg(CFG_PREFIX_LENGTH, 8'd2);
    send_text(4);
    send_req(KIND_TEXT, 6'd0, 4'd0, 8'h5a, 1'b1);
    send_req(KIND_TEXT, 6'd0, 4'd0, 8'h00, 1'b0);
    send_req(KIND_TEXT, 6'd0, 4'd0, 8'hff, 1'b1);

    // random phases, each under a different register setting
    write_reg(CFG_PREFIX_LENGTH, 8'd1);
    random_phase(180, 63);
    write_reg(CFG_PREFIX_LENGTH, 8'd4);
    write_reg(CFG_PATTERN_COUNT, 8'd20);
    gaps_on = 0;
    random_phase(300, 23);
    gaps_on = 1;
    write_reg(CFG_PREFIX_LENGTH, 8'd0);
    write_reg(CFG_PATTERN_COUNT, 8'hff);
    random_phase(420, 63);
    // sender holds off until every result is back
    drain();
    write_reg(CFG_PREFIX_LENGTH, 8'd7);
    write_reg(CFG_PATTERN_COUNT, 8'd0);
    random_phase(470, 15);
    write_reg(CFG_PATTERN_COUNT, 8'd8);
    write_reg(CFG_UNUSED, 8'h80);
    random_phase(560, 12);
    write_reg(CFG_PREFIX_LENGTH, 8'd3);
    write_reg(CFG_PATTERN_COUNT, 8'd64);
    random_phase(870, 63);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d requests, %0d results checked, %0d register writes",
             requests_sent, results_seen, cfg_writes);
    if (failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
